[hdl/mpc_pkg.sv]
// shared types, constants and register indexes for the matte pixel compositor
`timescale 1ns / 1ps
`default_nettype none

package mpc_pkg;

    // blend mode codes; the unused code behaves as solid colour
    localparam logic [1:0] MODE_PREMULT = 2'd0;
    localparam logic [1:0] MODE_DARK    = 2'd1;
    localparam logic [1:0] MODE_SOLID   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_BLEND_MODE   = 3'd0;
    localparam logic [2:0] REG_MATCH_ENABLE = 3'd1;
    localparam logic [2:0] REG_SOLID_COLOR  = 3'd2;
    localparam logic [2:0] REG_GAIN_BLUE    = 3'd3;
    localparam logic [2:0] REG_GAIN_GREEN   = 3'd4;
    localparam logic [2:0] REG_GAIN_RED     = 3'd5;

    localparam int CFG_DATA_W = 24;
    localparam int GAIN_W     = 10;

    localparam logic [23:0]       SOLID_RESET = 24'h1E2E2E;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 10'd256;

    // floor(x / 255) = (x * RECIP_255) >> RECIP_SHIFT, exact for x below 2^17
    localparam int          RECIP_SHIFT = 25;
    localparam logic [17:0] RECIP_255   = 18'd131587;

    typedef struct packed {
        logic [7:0] orig_blue;
        logic [7:0] orig_green;
        logic [7:0] orig_red;
        logic [7:0] fore_blue;
        logic [7:0] fore_green;
        logic [7:0] fore_red;
        logic       fore_valid;
        logic [7:0] alpha_code;
        logic       last_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
        logic       out_last;
    } pixel_out_t;

    // per-pixel control handed to each channel datapath
    typedef struct packed {
        logic [1:0] mode;
        logic       use_gain;
    } chan_ctrl_t;

endpackage

`default_nettype wire

[hdl/mpc_chan.sv]
// three-stage blend datapath for one colour channel
`timescale 1ns / 1ps
`default_nettype none

module mpc_chan
    import mpc_pkg::*;
(
    input  wire logic              clk,
    input  wire chan_ctrl_t        ctrl,
    input  wire logic [7:0]        orig,
    input  wire logic [7:0]        fore,
    input  wire logic              fore_valid,
    input  wire logic [7:0]        alpha,
    input  wire logic [GAIN_W-1:0] gain,
    input  wire logic [7:0]        solid,
    output logic [7:0]             result
);

    // stage 1: colour select and gain product
    chan_ctrl_t               ctrl_s1_reg;
    logic [7:0]               colour_s1_reg;
    logic [GAIN_W+7:0]        gprod_s1_reg;
    logic [7:0]               orig_s1_reg;
    logic [7:0]               solid_s1_reg;
    logic [7:0]               alpha_s1_reg;

    // stage 2: foreground and background products
    logic [15:0]              fg_s2_reg;
    logic [16:0]              bg_s2_reg;

    // stage 3: reciprocal divide
    logic [7:0]               result_reg;

    logic [7:0]               colour_next;
    logic [GAIN_W+7:0]        gprod_next;
    logic [7:0]               scaled;
    logic [7:0]               colour_s2;
    logic [7:0]               alpha_inv;
    logic [15:0]              orig_prod;
    logic [15:0]              solid_prod;
    logic [15:0]              fg_next;
    logic [16:0]              bg_next;
    logic [17:0]              num;
    logic [35:0]              quot_full;
    logic [7:0]               result_next;

    always_comb
    begin
        colour_next = fore_valid ? fore : orig;
        gprod_next  = {{GAIN_W{1'b0}}, colour_next} * {8'd0, gain};
    end

    always_ff @(posedge clk)
    begin
        ctrl_s1_reg   <= ctrl;
        colour_s1_reg <= colour_next;
        gprod_s1_reg  <= gprod_next;
        orig_s1_reg   <= orig;
        solid_s1_reg  <= solid;
        alpha_s1_reg  <= alpha;
    end

    always_comb
    begin
        // truncate by 8 fraction bits, saturate at 255
        scaled     = (gprod_s1_reg[GAIN_W+7:16] != '0) ? 8'hFF : gprod_s1_reg[15:8];
        colour_s2  = ctrl_s1_reg.use_gain ? scaled : colour_s1_reg;
        alpha_inv  = 8'hFF - alpha_s1_reg;
        fg_next    = colour_s2 * alpha_s1_reg;
        orig_prod  = orig_s1_reg * alpha_inv;
        solid_prod = solid_s1_reg * alpha_inv;
        priority if (ctrl_s1_reg.mode == MODE_PREMULT)
        begin
            bg_next = '0;
        end
        else if (ctrl_s1_reg.mode == MODE_DARK)
        begin
            bg_next = {1'b0, orig_prod};
        end
        else
        begin
            bg_next = {solid_prod, 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        fg_s2_reg <= fg_next;
        bg_s2_reg <= bg_next;
    end

    always_comb
    begin
        // num = 2*c*k + background + 255, then floor(num / 510) = floor((num >> 1) / 255)
        num         = {1'b0, fg_s2_reg, 1'b0} + {1'b0, bg_s2_reg} + 18'd255;
        quot_full   = {19'd0, num[17:1]} * {18'd0, RECIP_255};
        result_next = quot_full[RECIP_SHIFT+7:RECIP_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[hdl/matte_pixel_compositor.sv]
// top level of the matte pixel compositor: config registers, valid pipeline, channels
// a result word leaves after its pixel word has passed the valid_s1, valid_s2 and done registers
// throughput: one pixel word per clock, set by the three-stage channel datapath
// busy never rises; the receiver cannot stall, so nothing holds the pipeline
// reset clears the valid bits and loads the config registers with their defaults
`timescale 1ns / 1ps
`default_nettype none

module matte_pixel_compositor
    import mpc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire pixel_in_t             pix_in,
    input  wire logic                  cfg_wr_en,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       done,
    output pixel_out_t                 pix_out
);

    // configuration registers
    logic [1:0]        blend_mode_reg;
    logic              match_enable_reg;
    logic [23:0]       solid_color_reg;
    logic [GAIN_W-1:0] gain_blue_reg;
    logic [GAIN_W-1:0] gain_green_reg;
    logic [GAIN_W-1:0] gain_red_reg;

    // valid bits travelling alongside the channel stages
    logic              valid_s1_reg;
    logic              valid_s2_reg;
    logic              done_reg;

    // alpha and end-of-frame flag, pipelined to match the channels
    logic [7:0]        alpha_s1_reg;
    logic [7:0]        alpha_s2_reg;
    logic [7:0]        alpha_s3_reg;
    logic              last_s1_reg;
    logic              last_s2_reg;
    logic              last_s3_reg;

    logic              accept;
    chan_ctrl_t        ctrl;
    logic [7:0]        alpha_next;
    logic [7:0]        blue_res;
    logic [7:0]        green_res;
    logic [7:0]        red_res;

    // the pipeline never stalls, so a word is taken whenever start is high
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // register writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg   <= MODE_PREMULT;
            match_enable_reg <= 1'b0;
            solid_color_reg  <= SOLID_RESET;
            gain_blue_reg    <= GAIN_RESET;
            gain_green_reg   <= GAIN_RESET;
            gain_red_reg     <= GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BLEND_MODE:   blend_mode_reg   <= cfg_data[1:0];
                REG_MATCH_ENABLE: match_enable_reg <= cfg_data[0];
                REG_SOLID_COLOR:  solid_color_reg  <= cfg_data[23:0];
                REG_GAIN_BLUE:    gain_blue_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_GREEN:   gain_green_reg   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_RED:     gain_red_reg     <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // gain only applies to the premultiplied mode
    always_comb
    begin
        ctrl.mode     = blend_mode_reg;
        ctrl.use_gain = (blend_mode_reg == MODE_PREMULT) && match_enable_reg;
        alpha_next    = (blend_mode_reg == MODE_PREMULT) ? pix_in.alpha_code : 8'hFF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= accept;
            valid_s2_reg <= valid_s1_reg;
            done_reg     <= valid_s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_s1_reg <= alpha_next;
        alpha_s2_reg <= alpha_s1_reg;
        alpha_s3_reg <= alpha_s2_reg;
        last_s1_reg  <= pix_in.last_pixel;
        last_s2_reg  <= last_s1_reg;
        last_s3_reg  <= last_s2_reg;
    end

    // one datapath per colour channel; solid colour is blue-green-red from the top byte
    mpc_chan u_chan_blue (
        .clk        (clk),
        .ctrl       (ctrl),
        .orig       (pix_in.orig_blue),
        .fore       (pix_in.fore_blue),
        .fore_valid (pix_in.fore_valid),
        .alpha      (pix_in.alpha_code),
        .gain       (gain_blue_reg),
        .solid      (solid_color_reg[23:16]),
        .result     (blue_res)
    );

    mpc_chan u_chan_green (
        .clk        (clk),
        .ctrl       (ctrl),
        .orig       (pix_in.orig_green),
        .fore       (pix_in.fore_green),
        .fore_valid (pix_in.fore_valid),
        .alpha      (pix_in.alpha_code),
        .gain       (gain_green_reg),
        .solid      (solid_color_reg[15:8]),
        .result     (green_res)
    );

    mpc_chan u_chan_red (
        .clk        (clk),
        .ctrl       (ctrl),
        .orig       (pix_in.orig_red),
        .fore       (pix_in.fore_red),
        .fore_valid (pix_in.fore_valid),
        .alpha      (pix_in.alpha_code),
        .gain       (gain_red_reg),
        .solid      (solid_color_reg[7:0]),
        .result     (red_res)
    );

    // output word, strobed by done for exactly one cycle
    assign done              = done_reg;
    assign pix_out.out_blue  = blue_res;
    assign pix_out.out_green = green_res;
    assign pix_out.out_red   = red_res;
    assign pix_out.out_alpha = alpha_s3_reg;
    assign pix_out.out_last  = last_s3_reg;

    // every accepted word comes out through the valid pipeline and raises done
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("accepted word did not reach the output");

    // no result word without a matching word accepted at the input
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result word without a matching input word");

    // frame marker stays aligned with its pixel
    a_last_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pix_out.out_last == $past(pix_in.last_pixel, 3)))
        else $error("end-of-frame flag out of step with its pixel");

    // a non-opaque alpha can only be the pixel's own alpha code
    a_alpha_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (pix_out.out_alpha != 8'hFF))
            |-> (pix_out.out_alpha == $past(pix_in.alpha_code, 3)))
        else $error("output alpha does not match the pixel alpha code");

endmodule

`default_nettype wire
